// ----- rtl/core/varm_pkg.sv -----
`default_nettype none
package varm_pkg;

  localparam int COMPONENT_WIDTH_DEF = 16;
  localparam int FRACTION_BITS_DEF   = 14;

  // internal fraction bits of the unit vectors and the angle terms
  localparam int G  = 30;
  // lane width of the normalizer, wide enough for a full 32-bit component
  localparam int VW = 32;
  // quotient bits of the normalizer divide (unit components stay within 2^G)
  localparam int QW = G + 1;
  // root bits of the square roots
  localparam int SW = 32;
  // width used for rounding products back to G fraction bits
  localparam int RNW = 72;

  localparam logic [1:0] REG_REFERENCE_X = 2'd0;
  localparam logic [1:0] REG_REFERENCE_Y = 2'd1;
  localparam logic [1:0] REG_REFERENCE_Z = 2'd2;

  typedef logic [2:0][VW-1:0] vec3_t;

  localparam logic signed [RNW-1:0] RND_HALF = RNW'(1) << (G - 1);

  // round to nearest, ties away from zero, dropping G fraction bits
  function automatic logic signed [RNW-1:0] rnd_g(input logic signed [RNW-1:0] v);
    logic signed [RNW-1:0] t;
    t = v + RND_HALF - {{(RNW-1){1'b0}}, v[RNW-1]};
    return t >>> G;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/varm_isqrt.sv -----
`default_nettype none
module varm_isqrt #(
  parameter int RW  = varm_pkg::SW,
  parameter int SBW = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [2*RW-1:0] radicand,
  input  logic [SBW-1:0]  in_sb,
  output logic            out_valid,
  output logic [RW-1:0]   root,
  output logic [SBW-1:0]  out_sb
);

  logic            v   [RW+1];
  logic [2*RW-1:0] xs  [RW+1];
  logic [RW+1:0]   rem [RW+1];
  logic [RW-1:0]   rt  [RW+1];
  logic [SBW-1:0]  sb  [RW+1];

  assign v[0]   = in_valid;
  assign xs[0]  = radicand;
  assign rem[0] = '0;
  assign rt[0]  = '0;
  assign sb[0]  = in_sb;

  // one root bit per stage, two radicand bits consumed each time
  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [RW+3:0] rn;
    logic [RW+3:0] tr;
    logic [RW+3:0] rd;
    logic          ge;

    always_comb begin
      rn = {rem[k], xs[k][2*RW-1 -: 2]};
      tr = {2'b00, rt[k], 2'b01};
      rd = rn - tr;
      ge = rn >= tr;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      xs[k+1]  <= xs[k] << 2;
      rem[k+1] <= ge ? rd[RW+1:0] : rn[RW+1:0];
      rt[k+1]  <= {rt[k][RW-2:0], ge};
      sb[k+1]  <= sb[k];
    end
  end

  assign out_valid = v[RW];
  assign root      = rt[RW];
  assign out_sb    = sb[RW];

endmodule
`default_nettype wire

// ----- rtl/core/varm_unit.sv -----
`default_nettype none
module varm_unit #(
  parameter int SBW = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  varm_pkg::vec3_t   vin,
  input  logic [SBW-1:0]    in_sb,
  output logic              out_valid,
  output varm_pkg::vec3_t   vout,
  output logic              zero,
  output logic [SBW-1:0]    out_sb
);

  localparam int MW    = varm_pkg::VW;
  localparam int QW    = varm_pkg::QW;
  localparam int NW    = MW + QW;
  localparam int NSTEP = $clog2(MW);
  localparam int IW    = 3*MW + 3 + 1 + SBW;

  // magnitudes and their maximum
  logic [2:0][MW-1:0] mag;
  logic [MW-1:0]      mx;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = vin[i][MW-1] ? (MW'(0) - vin[i]) : vin[i];
    end
    mx = mag[0];
    if (mag[1] > mx) mx = mag[1];
    if (mag[2] > mx) mx = mag[2];
  end

  // normalize: shift all lanes until the largest reaches 2^(MW-2)
  logic               nv   [NSTEP+1];
  varm_pkg::vec3_t    nm   [NSTEP+1];
  logic [MW-1:0]      nmx  [NSTEP+1];
  logic [2:0]         nneg [NSTEP+1];
  logic               nz   [NSTEP+1];
  logic [SBW-1:0]     nsb  [NSTEP+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      nv[0] <= 1'b0;
    end else begin
      nv[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    nm[0]   <= mag;
    nmx[0]  <= mx;
    nneg[0] <= {vin[2][MW-1], vin[1][MW-1], vin[0][MW-1]};
    nz[0]   <= mx == '0;
    nsb[0]  <= in_sb;
  end

  for (genvar k = 0; k < NSTEP; k++) begin : g_norm
    localparam int S = 1 << (NSTEP - 1 - k);
    logic sh;
    assign sh = (nmx[k] >> (MW - 1 - S)) == '0;

    always_ff @(posedge clk) begin
      if (rst) begin
        nv[k+1] <= 1'b0;
      end else begin
        nv[k+1] <= nv[k];
      end
    end

    always_ff @(posedge clk) begin
      nmx[k+1] <= sh ? (nmx[k] << S) : nmx[k];
      for (int i = 0; i < 3; i++) begin
        nm[k+1][i] <= sh ? (nm[k][i] << S) : nm[k][i];
      end
      nneg[k+1] <= nneg[k];
      nz[k+1]   <= nz[k];
      nsb[k+1]  <= nsb[k];
    end
  end

  // squares, then their sum
  logic            sq_valid;
  logic [2*MW-1:0] sq [3];
  varm_pkg::vec3_t sq_m;
  logic [2:0]      sq_neg;
  logic            sq_z;
  logic [SBW-1:0]  sq_sb;

  logic            ss_valid;
  logic [2*MW-1:0] ss;
  varm_pkg::vec3_t ss_m;
  logic [2:0]      ss_neg;
  logic            ss_z;
  logic [SBW-1:0]  ss_sb;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
      ss_valid <= 1'b0;
    end else begin
      sq_valid <= nv[NSTEP];
      ss_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq[i] <= (2*MW)'(nm[NSTEP][i]) * (2*MW)'(nm[NSTEP][i]);
    end
    sq_m   <= nm[NSTEP];
    sq_neg <= nneg[NSTEP];
    sq_z   <= nz[NSTEP];
    sq_sb  <= nsb[NSTEP];
    ss     <= sq[0] + sq[1] + sq[2];
    ss_m   <= sq_m;
    ss_neg <= sq_neg;
    ss_z   <= sq_z;
    ss_sb  <= sq_sb;
  end

  // norm
  logic            rt_valid;
  logic [MW-1:0]   nrm;
  logic [IW-1:0]   rt_sb;
  varm_pkg::vec3_t rt_m;
  logic [2:0]      rt_neg;
  logic            rt_z;
  logic [SBW-1:0]  rt_sbo;

  varm_isqrt #(
    .RW  (MW),
    .SBW (IW)
  ) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ss_valid),
    .radicand  (ss),
    .in_sb     ({ss_m, ss_neg, ss_z, ss_sb}),
    .out_valid (rt_valid),
    .root      (nrm),
    .out_sb    (rt_sb)
  );

  assign {rt_m, rt_neg, rt_z, rt_sbo} = rt_sb;

  // divide: round(m * 2^G / nrm), one quotient bit per stage in each lane
  logic               dv   [QW+1];
  varm_pkg::vec3_t    drem [QW+1];
  logic [2:0][QW-1:0] dlow [QW+1];
  logic [2:0][QW-1:0] dq   [QW+1];
  logic [MW-1:0]      dd   [QW+1];
  logic [2:0]         dneg [QW+1];
  logic               dz   [QW+1];
  logic [SBW-1:0]     dsb  [QW+1];

  logic [2:0][NW-1:0] num;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = (NW'(rt_m[i]) << varm_pkg::G) + NW'(nrm >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else begin
      dv[0] <= rt_valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      drem[0][i] <= num[i][NW-1 -: MW];
      dlow[0][i] <= num[i][QW-1:0];
    end
    dq[0]   <= '0;
    dd[0]   <= nrm;
    dneg[0] <= rt_neg;
    dz[0]   <= rt_z;
    dsb[0]  <= rt_sbo;
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [2:0][MW:0] r2;
    logic [2:0][MW:0] df;
    logic [2:0]       ge;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        r2[i] = {drem[k][i], dlow[k][i][QW-1]};
        df[i] = r2[i] - {1'b0, dd[k]};
        ge[i] = r2[i] >= {1'b0, dd[k]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else begin
        dv[k+1] <= dv[k];
      end
    end

    always_ff @(posedge clk) begin
      for (int i = 0; i < 3; i++) begin
        drem[k+1][i] <= ge[i] ? df[i][MW-1:0] : r2[i][MW-1:0];
        dlow[k+1][i] <= dlow[k][i] << 1;
        dq[k+1][i]   <= {dq[k][i][QW-2:0], ge[i]};
      end
      dd[k+1]   <= dd[k];
      dneg[k+1] <= dneg[k];
      dz[k+1]   <= dz[k];
      dsb[k+1]  <= dsb[k];
    end
  end

  // put the signs back
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= dv[QW];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      vout[i] <= dneg[QW][i] ? (MW'(0) - MW'(dq[QW][i])) : MW'(dq[QW][i]);
    end
    zero   <= dz[QW];
    out_sb <= dsb[QW];
  end

endmodule
`default_nettype wire

// ----- rtl/core/vector_align_rotation_matrix_unit.sv -----
`default_nettype none
// Rotation matrix that turns the reference vector onto each incoming normal.
// Throughput: one word per cycle; busy stays low, every stage is a register
// and the three normalizers and the square roots are fully pipelined.
// Reset: sync, restores the reference registers and flushes every valid bit.
// The receiver cannot stall; each result is shown for one cycle only.
module vector_align_rotation_matrix_unit #(
  parameter int COMPONENT_WIDTH = varm_pkg::COMPONENT_WIDTH_DEF,
  parameter int FRACTION_BITS   = varm_pkg::FRACTION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [COMPONENT_WIDTH-1:0] normal_x,
  input  logic signed [COMPONENT_WIDTH-1:0] normal_y,
  input  logic signed [COMPONENT_WIDTH-1:0] normal_z,
  input  logic                              wr_en,
  input  logic [1:0]                        wr_index,
  input  logic [COMPONENT_WIDTH-1:0]        wr_data,
  output logic                              done,
  output logic signed [COMPONENT_WIDTH-1:0] m00,
  output logic signed [COMPONENT_WIDTH-1:0] m01,
  output logic signed [COMPONENT_WIDTH-1:0] m02,
  output logic signed [COMPONENT_WIDTH-1:0] m10,
  output logic signed [COMPONENT_WIDTH-1:0] m11,
  output logic signed [COMPONENT_WIDTH-1:0] m12,
  output logic signed [COMPONENT_WIDTH-1:0] m20,
  output logic signed [COMPONENT_WIDTH-1:0] m21,
  output logic signed [COMPONENT_WIDTH-1:0] m22,
  output logic                              degenerate
);

  localparam int CW = COMPONENT_WIDTH;
  localparam int VW = varm_pkg::VW;
  localparam int G  = varm_pkg::G;
  localparam int RN = varm_pkg::RNW;
  localparam int SH = G - FRACTION_BITS;

  localparam logic signed [36:0] HI   = (37'sd1 <<< (CW - 1)) - 37'sd1;
  localparam logic signed [36:0] LO   = -HI - 37'sd1;
  localparam logic signed [36:0] HALF = (SH > 0) ? (37'sd1 <<< ((SH > 0) ? SH - 1 : 0)) : '0;
  localparam logic [CW-1:0] REF_Y_RST =
    (FRACTION_BITS >= CW - 1) ? HI[CW-1:0] : CW'(37'sd1 <<< FRACTION_BITS);

  localparam logic signed [VW-1:0] G_ONE  = VW'(64'sd1 <<< G);
  localparam logic [63:0]          G_ONE2 = 64'd1 << (2 * G);

  function automatic logic [CW-1:0] to_out(input logic signed [35:0] v);
    logic signed [36:0] t;
    t = 37'(v);
    if (SH > 0) begin
      t = t + HALF - {36'd0, v[35]};
      t = t >>> SH;
    end
    if (t > HI) t = HI;
    if (t < LO) t = LO;
    return t[CW-1:0];
  endfunction

  assign busy = 1'b0;

  // reference registers
  logic [CW-1:0] ref_x;
  logic [CW-1:0] ref_y;
  logic [CW-1:0] ref_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_x <= '0;
      ref_y <= REF_Y_RST;
      ref_z <= '0;
    end else if (wr_en) begin
      case (wr_index)
        varm_pkg::REG_REFERENCE_X: ref_x <= wr_data;
        varm_pkg::REG_REFERENCE_Y: ref_y <= wr_data;
        varm_pkg::REG_REFERENCE_Z: ref_z <= wr_data;
        default: ;
      endcase
    end
  end

  // entry, exact parallel test
  logic                 e_valid;
  logic [2:0][CW-1:0]   e_r;
  logic [2:0][CW-1:0]   e_n;
  logic                 p_valid;
  logic [2:0][CW-1:0]   p_r;
  logic [2:0][CW-1:0]   p_n;
  logic signed [2*CW-1:0] prod [6];
  logic                 f_valid;
  logic                 f_par;
  varm_pkg::vec3_t      f_r;
  varm_pkg::vec3_t      f_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
      p_valid <= 1'b0;
      f_valid <= 1'b0;
    end else begin
      e_valid <= start;
      p_valid <= e_valid;
      f_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    e_r <= {ref_z, ref_y, ref_x};
    e_n <= {normal_z, normal_y, normal_x};
    p_r <= e_r;
    p_n <= e_n;
    prod[0] <= $signed(e_r[1]) * $signed(e_n[2]);
    prod[1] <= $signed(e_r[2]) * $signed(e_n[1]);
    prod[2] <= $signed(e_r[2]) * $signed(e_n[0]);
    prod[3] <= $signed(e_r[0]) * $signed(e_n[2]);
    prod[4] <= $signed(e_r[0]) * $signed(e_n[1]);
    prod[5] <= $signed(e_r[1]) * $signed(e_n[0]);
    f_par <= (prod[0] == prod[1]) && (prod[2] == prod[3]) && (prod[4] == prod[5]);
    for (int i = 0; i < 3; i++) begin
      f_r[i] <= VW'($signed(p_r[i]));
      f_n[i] <= VW'($signed(p_n[i]));
    end
  end

  // unit reference and unit normal
  varm_pkg::vec3_t a_v;
  varm_pkg::vec3_t b_v;
  logic            zr;
  logic            zn;
  logic            par_u;
  logic            un_valid;

  varm_unit #(
    .SBW (1)
  ) u_unit_r (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .vin       (f_r),
    .in_sb     (f_par),
    .out_valid (),
    .vout      (a_v),
    .zero      (zr),
    .out_sb    (par_u)
  );

  varm_unit #(
    .SBW (1)
  ) u_unit_n (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .vin       (f_n),
    .in_sb     (1'b0),
    .out_valid (un_valid),
    .vout      (b_v),
    .zero      (zn),
    .out_sb    ()
  );

  // cross and dot products
  logic               x_valid;
  logic               x_deg;
  logic signed [63:0] xp [9];
  logic               y_valid;
  logic               y_deg;
  logic signed [65:0] y_w [3];
  logic signed [65:0] y_d;
  logic               z_valid;
  logic               z_deg;
  varm_pkg::vec3_t    z_w;
  logic signed [VW-1:0] z_c;

  logic signed [RN-1:0] wr_r [3];
  logic signed [RN-1:0] dr_r;
  logic signed [VW-1:0] c_cl;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wr_r[i] = varm_pkg::rnd_g(RN'(y_w[i]));
    end
    dr_r = varm_pkg::rnd_g(RN'(y_d));
    if (dr_r > RN'(G_ONE)) begin
      c_cl = G_ONE;
    end else if (dr_r < -RN'(G_ONE)) begin
      c_cl = -G_ONE;
    end else begin
      c_cl = dr_r[VW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_valid <= 1'b0;
      y_valid <= 1'b0;
      z_valid <= 1'b0;
    end else begin
      x_valid <= un_valid;
      y_valid <= x_valid;
      z_valid <= y_valid;
    end
  end

  always_ff @(posedge clk) begin
    x_deg <= zr | zn | par_u;
    xp[0] <= $signed(a_v[1]) * $signed(b_v[2]);
    xp[1] <= $signed(a_v[2]) * $signed(b_v[1]);
    xp[2] <= $signed(a_v[2]) * $signed(b_v[0]);
    xp[3] <= $signed(a_v[0]) * $signed(b_v[2]);
    xp[4] <= $signed(a_v[0]) * $signed(b_v[1]);
    xp[5] <= $signed(a_v[1]) * $signed(b_v[0]);
    xp[6] <= $signed(a_v[0]) * $signed(b_v[0]);
    xp[7] <= $signed(a_v[1]) * $signed(b_v[1]);
    xp[8] <= $signed(a_v[2]) * $signed(b_v[2]);
    y_deg  <= x_deg;
    y_w[0] <= 66'(xp[0]) - 66'(xp[1]);
    y_w[1] <= 66'(xp[2]) - 66'(xp[3]);
    y_w[2] <= 66'(xp[4]) - 66'(xp[5]);
    y_d    <= 66'(xp[6]) + 66'(xp[7]) + 66'(xp[8]);
    z_deg <= y_deg;
    for (int i = 0; i < 3; i++) begin
      z_w[i] <= wr_r[i][VW-1:0];
    end
    z_c <= c_cl;
  end

  // unit axis, cosine rides along
  varm_pkg::vec3_t      u_v;
  logic                 uw_valid;
  logic                 wzero;
  logic signed [VW-1:0] u_c;
  logic                 u_deg;

  varm_unit #(
    .SBW (VW + 1)
  ) u_unit_w (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (z_valid),
    .vin       (z_w),
    .in_sb     ({z_c, z_deg}),
    .out_valid (uw_valid),
    .vout      (u_v),
    .zero      (wzero),
    .out_sb    ({u_c, u_deg})
  );

  // sine = sqrt(1 - c^2)
  logic                 c2_valid;
  varm_pkg::vec3_t      c2_u;
  logic signed [VW-1:0] c2_c;
  logic                 c2_deg;
  logic signed [63:0]   c2_sq;
  logic                 s_valid;
  logic [63:0]          s_x;
  varm_pkg::vec3_t      s_u;
  logic signed [VW-1:0] s_c;
  logic                 s_deg;

  always_ff @(posedge clk) begin
    if (rst) begin
      c2_valid <= 1'b0;
      s_valid  <= 1'b0;
    end else begin
      c2_valid <= uw_valid;
      s_valid  <= c2_valid;
    end
  end

  always_ff @(posedge clk) begin
    c2_u   <= u_v;
    c2_c   <= u_c;
    c2_deg <= u_deg | wzero;
    c2_sq  <= u_c * u_c;
    s_x    <= G_ONE2 - c2_sq;
    s_u    <= c2_u;
    s_c    <= c2_c;
    s_deg  <= c2_deg;
  end

  logic                  q_valid;
  logic [VW-1:0]         s_root;
  varm_pkg::vec3_t       q_u;
  logic signed [VW-1:0]  q_c;
  logic                  q_deg;

  varm_isqrt #(
    .RW  (varm_pkg::SW),
    .SBW (4 * VW + 1)
  ) u_sine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_valid),
    .radicand  (s_x),
    .in_sb     ({s_u, s_c, s_deg}),
    .out_valid (q_valid),
    .root      (s_root),
    .out_sb    ({q_u, q_c, q_deg})
  );

  // Rodrigues terms: uu in order 00 01 02 11 12 22
  logic                 m1_valid, m2_valid, m3_valid, m4_valid;
  logic                 m1_deg, m2_deg, m3_deg, m4_deg;
  logic signed [VW-1:0] m1_c, m2_c, m3_c, m4_c;
  logic signed [32:0]   m1_omc, m2_omc;
  logic signed [63:0]   m1_uu [6];
  logic signed [63:0]   m1_su [3];
  logic signed [31:0]   m2_ku [6];
  logic signed [31:0]   m2_q  [3];
  logic signed [64:0]   m3_kp [6];
  logic signed [31:0]   m3_q  [3];
  logic signed [33:0]   m4_k  [6];
  logic signed [31:0]   m4_q  [3];

  logic signed [RN-1:0] ku_r [6];
  logic signed [RN-1:0] q_r  [3];
  logic signed [RN-1:0] k_r  [6];

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      ku_r[i] = varm_pkg::rnd_g(RN'(m1_uu[i]));
      k_r[i]  = varm_pkg::rnd_g(RN'(m3_kp[i]));
    end
    for (int i = 0; i < 3; i++) begin
      q_r[i] = varm_pkg::rnd_g(RN'(m1_su[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
      m2_valid <= 1'b0;
      m3_valid <= 1'b0;
      m4_valid <= 1'b0;
    end else begin
      m1_valid <= q_valid;
      m2_valid <= m1_valid;
      m3_valid <= m2_valid;
      m4_valid <= m3_valid;
    end
  end

  always_ff @(posedge clk) begin
    m1_uu[0] <= $signed(q_u[0]) * $signed(q_u[0]);
    m1_uu[1] <= $signed(q_u[0]) * $signed(q_u[1]);
    m1_uu[2] <= $signed(q_u[0]) * $signed(q_u[2]);
    m1_uu[3] <= $signed(q_u[1]) * $signed(q_u[1]);
    m1_uu[4] <= $signed(q_u[1]) * $signed(q_u[2]);
    m1_uu[5] <= $signed(q_u[2]) * $signed(q_u[2]);
    for (int i = 0; i < 3; i++) begin
      m1_su[i] <= $signed(s_root) * $signed(q_u[i]);
    end
    m1_omc <= 33'(G_ONE) - 33'(q_c);
    m1_c   <= q_c;
    m1_deg <= q_deg;

    for (int i = 0; i < 6; i++) begin
      m2_ku[i] <= ku_r[i][31:0];
    end
    for (int i = 0; i < 3; i++) begin
      m2_q[i] <= q_r[i][31:0];
    end
    m2_omc <= m1_omc;
    m2_c   <= m1_c;
    m2_deg <= m1_deg;

    for (int i = 0; i < 6; i++) begin
      m3_kp[i] <= 65'(m2_ku[i]) * 65'(m2_omc);
    end
    m3_q   <= m2_q;
    m3_c   <= m2_c;
    m3_deg <= m2_deg;

    for (int i = 0; i < 6; i++) begin
      m4_k[i] <= k_r[i][33:0];
    end
    m4_q   <= m3_q;
    m4_c   <= m3_c;
    m4_deg <= m3_deg;
  end

  // assemble, identity on degenerate
  logic               a_valid;
  logic               a_deg;
  logic signed [35:0] a_mat [9];
  logic signed [35:0] mat   [9];

  always_comb begin
    mat[0] = 36'(m4_c) + 36'(m4_k[0]);
    mat[1] = 36'(m4_k[1]) - 36'(m4_q[2]);
    mat[2] = 36'(m4_k[2]) + 36'(m4_q[1]);
    mat[3] = 36'(m4_k[1]) + 36'(m4_q[2]);
    mat[4] = 36'(m4_c) + 36'(m4_k[3]);
    mat[5] = 36'(m4_k[4]) - 36'(m4_q[0]);
    mat[6] = 36'(m4_k[2]) - 36'(m4_q[1]);
    mat[7] = 36'(m4_k[4]) + 36'(m4_q[0]);
    mat[8] = 36'(m4_c) + 36'(m4_k[5]);
    if (m4_deg) begin
      for (int i = 0; i < 9; i++) begin
        mat[i] = (i % 4 == 0) ? 36'(G_ONE) : 36'sd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      done    <= 1'b0;
    end else begin
      a_valid <= m4_valid;
      done    <= a_valid;
    end
  end

  logic [CW-1:0] o_m [9];

  always_ff @(posedge clk) begin
    a_mat <= mat;
    a_deg <= m4_deg;
    for (int i = 0; i < 9; i++) begin
      o_m[i] <= to_out(a_mat[i]);
    end
    degenerate <= a_deg;
  end

  assign m00 = o_m[0];
  assign m01 = o_m[1];
  assign m02 = o_m[2];
  assign m10 = o_m[3];
  assign m11 = o_m[4];
  assign m12 = o_m[5];
  assign m20 = o_m[6];
  assign m21 = o_m[7];
  assign m22 = o_m[8];

endmodule
`default_nettype wire
